### hdl/gfau_pkg.sv
// Shared definitions for the GF(2^n) arithmetic unit.
// Holds the default field width, the modulus reset value, the opcodes and the sequencer states.
// Depends on nothing; every other file of the block imports it.
package gfau_pkg;

  // Default field width and the low bits of the default modulus x^8+x^4+x^3+x+1.
  localparam int unsigned FIELD_BITS = 8;
  localparam logic [15:0] POLY_RESET = 16'h001b;

  // Operation codes carried by a request transaction.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_DIV = 2'd2,
    OP_INV = 2'd3
  } gfau_op_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_INV,
    ST_DONE
  } gfau_state_e;

endpackage

### hdl/gfau_req_if.sv
// Request channel of the GF(2^n) arithmetic unit: valid/ready handshake and the operation payload.
// Depends on gfau_pkg for the default field width.
interface gfau_req_if
  import gfau_pkg::*;
#(
  parameter int unsigned FieldBits = FIELD_BITS
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [FieldBits-1:0] operand_a;
  logic [FieldBits-1:0] operand_b;

  modport source (output valid, operation, operand_a, operand_b, input ready);
  modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

### hdl/gfau_rsp_if.sv
// Response channel of the GF(2^n) arithmetic unit: valid/ready handshake and the result payload.
// Depends on gfau_pkg for the default field width.
interface gfau_rsp_if
  import gfau_pkg::*;
#(
  parameter int unsigned FieldBits = FIELD_BITS
);
  logic                 valid;
  logic                 ready;
  logic [FieldBits-1:0] result_value;
  logic [FieldBits-1:0] remainder_value;
  logic                 error_flag;

  modport source (output valid, result_value, remainder_value, error_flag, input ready);
  modport sink   (input valid, result_value, remainder_value, error_flag, output ready);
endinterface

### hdl/gf256_arith_unit_top.sv
// Top level of the GF(2^n) arithmetic unit: sequencer and shared reduce/shift datapath.
// Depends on gfau_pkg, gfau_req_if and gfau_rsp_if.
//
// Usage: a request transaction on req_i carries an operation (add, multiply, divide or
// inverse of operand_a) and two field elements. Exactly one response transaction follows
// on rsp_o with the result, the division remainder and an error flag. The low bits of the
// field modulus (the x^FieldBits term is implicit) are written through cfg_wr_en_i and
// cfg_wr_data_i only while the unit is idle, which the user must ensure; it is unchecked.
// The unit holds one transaction at a time: req_i.ready is high only when it is idle.
// Add and divide by zero go from idle straight to the response state; multiply, divide
// and inverse first run their loops below. A new request is accepted only after the
// response has been taken and the sequencer is back in idle, so an item is finished
// before the next one is taken.
// The multiply loop runs one bit of operand_b per cycle; divide and inverse share one
// unit that each cycle cancels the leading term of one remainder with a shifted copy of
// the other, or for inverse swaps the two, so their length follows the operand degrees.
// The response is held in registers and stays valid until the receiver takes it; a
// stalled receiver simply keeps the unit from accepting the next request.
// Reset returns the sequencer to idle and the modulus to x^8+x^4+x^3+x+1.
module gf256_arith_unit_top
  import gfau_pkg::*;
#(
  parameter int unsigned FieldBits = FIELD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_wr_en_i,
  input  logic [FieldBits-1:0] cfg_wr_data_i,
  gfau_req_if.sink             req_i,
  gfau_rsp_if.source           rsp_o
);

  localparam int unsigned DegW = $clog2(FieldBits + 1);
  localparam int unsigned CntW = $clog2(FieldBits + 1);

  // Index of the highest set bit; a zero word gives zero and is handled by the caller.
  function automatic logic [DegW-1:0] deg_of(input logic [FieldBits:0] p);
    logic [DegW-1:0] d;
    d = '0;
    for (int i = 0; i <= FieldBits; i++) begin
      if (p[i]) begin
        d = DegW'(i);
      end
    end
    return d;
  endfunction

  gfau_state_e          state_q, state_d;
  logic [FieldBits-1:0] poly_q;
  logic [FieldBits:0]   r0_q, r1_q, t0_q, t1_q;
  logic [CntW-1:0]      cnt_q;
  logic [FieldBits-1:0] res_q, rem_q;
  logic                 err_q;

  gfau_op_e             req_op;
  logic                 req_fire;
  logic                 rsp_fire;
  logic [DegW-1:0]      deg0, deg1, shamt;
  logic                 can_reduce;
  logic [FieldBits:0]   r0_red, t0_red;
  logic [FieldBits:0]   mul_p;
  logic                 mul_last;
  logic                 inv_done;

  assign req_op   = gfau_op_e'(req_i.operation);
  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_fire = rsp_o.valid && rsp_o.ready;

  // Shared reduce unit: cancel the leading term of r0 with r1 shifted to the same degree,
  // and apply the same shift to the cofactor pair.
  assign deg0       = deg_of(r0_q);
  assign deg1       = deg_of(r1_q);
  assign shamt      = deg0 - deg1;
  assign can_reduce = (r0_q != '0) && (r1_q != '0) && (deg0 >= deg1);
  assign r0_red     = r0_q ^ (r1_q << shamt);
  assign t0_red     = t0_q ^ (t1_q << shamt);
  assign inv_done   = (r1_q == '0);

  // Multiply step, most significant bit of operand_b first: double, reduce, add.
  always_comb begin
    mul_p = {r0_q[FieldBits-1:0], 1'b0};
    if (mul_p[FieldBits]) begin
      mul_p = mul_p ^ {1'b1, poly_q};
    end
    if (t1_q[FieldBits-1]) begin
      mul_p = mul_p ^ {1'b0, r1_q[FieldBits-1:0]};
    end
  end

  assign mul_last = (cnt_q == '0);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          case (req_op)
            OP_ADD:  state_d = ST_DONE;
            OP_MUL:  state_d = ST_MUL;
            OP_DIV:  state_d = (req_i.operand_b == '0) ? ST_DONE : ST_DIV;
            OP_INV:  state_d = ST_INV;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_MUL: begin
        if (mul_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (!can_reduce) begin
          state_d = ST_DONE;
        end
      end
      ST_INV: begin
        if (inv_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs follow the state alone.
  always_comb begin
    req_i.ready = 1'b0;
    rsp_o.valid = 1'b0;
    case (state_q)
      ST_IDLE: req_i.ready = 1'b1;
      ST_DONE: rsp_o.valid = 1'b1;
      default: begin
        req_i.ready = 1'b0;
        rsp_o.valid = 1'b0;
      end
    endcase
  end

  assign rsp_o.result_value    = res_q;
  assign rsp_o.remainder_value = rem_q;
  assign rsp_o.error_flag      = err_q;

  // Control state and the modulus register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      poly_q  <= POLY_RESET[FieldBits-1:0];
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) begin
        poly_q <= cfg_wr_data_i;
      end
    end
  end

  // Working registers and the response registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          res_q <= '0;
          rem_q <= '0;
          err_q <= 1'b0;
          t0_q  <= '0;
          t1_q  <= {{FieldBits{1'b0}}, 1'b1};
          r1_q  <= {1'b0, req_i.operand_a};
          cnt_q <= CntW'(FieldBits - 1);
          case (req_op)
            OP_ADD: begin
              res_q <= req_i.operand_a ^ req_i.operand_b;
            end
            OP_MUL: begin
              r0_q <= '0;
              t1_q <= {1'b0, req_i.operand_b};
            end
            OP_DIV: begin
              r0_q  <= {1'b0, req_i.operand_a};
              r1_q  <= {1'b0, req_i.operand_b};
              err_q <= (req_i.operand_b == '0);
            end
            OP_INV: begin
              r0_q <= {1'b1, poly_q};
            end
            default: begin
              r0_q <= '0;
            end
          endcase
        end
      end
      ST_MUL: begin
        r0_q  <= mul_p;
        t1_q  <= t1_q << 1;
        cnt_q <= cnt_q - CntW'(1);
        if (mul_last) begin
          res_q <= mul_p[FieldBits-1:0];
        end
      end
      ST_DIV: begin
        if (can_reduce) begin
          r0_q <= r0_red;
          t0_q <= t0_red;
        end else begin
          res_q <= t0_q[FieldBits-1:0];
          rem_q <= r0_q[FieldBits-1:0];
        end
      end
      ST_INV: begin
        if (inv_done) begin
          // The gcd is left in r0; only a unit gcd has an inverse.
          if (r0_q == {{FieldBits{1'b0}}, 1'b1}) begin
            res_q <= t0_q[FieldBits-1:0];
          end else begin
            err_q <= 1'b1;
          end
        end else if (can_reduce) begin
          r0_q <= r0_red;
          t0_q <= t0_red;
        end else begin
          r0_q <= r1_q;
          r1_q <= r0_q;
          t0_q <= t1_q;
          t1_q <= t0_q;
        end
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

endmodule

### hdl/gfau_checker.sv
// Port-level checks for the GF(2^n) arithmetic unit and the bind that attaches them.
// Depends on gfau_pkg and on gf256_arith_unit_top.
module gfau_checker
  import gfau_pkg::*;
#(
  parameter int unsigned FieldBits = FIELD_BITS
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input logic [FieldBits-1:0] rsp_result,
  input logic [FieldBits-1:0] rsp_remainder,
  input logic                 rsp_error
);

  // A stalled response keeps its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result) &&
                                $stable(rsp_remainder) && $stable(rsp_error))
    else $error("stalled response changed");

  // No request is taken while a response is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready)
    else $error("request ready while a response is pending");

  // Once a request transaction is taken the unit is busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("unit ready again right after accepting a request");

  // An error response carries neither a remainder nor a result: both are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_error |-> rsp_remainder == '0 && rsp_result == '0)
    else $error("error response with non-zero payload");

endmodule

bind gf256_arith_unit_top gfau_checker #(
  .FieldBits(FieldBits)
) u_gfau_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid    (req_i.valid),
  .req_ready    (req_i.ready),
  .rsp_valid    (rsp_o.valid),
  .rsp_ready    (rsp_o.ready),
  .rsp_result   (rsp_o.result_value),
  .rsp_remainder(rsp_o.remainder_value),
  .rsp_error    (rsp_o.error_flag)
);

### bench/tb.sv
// Self-checking testbench for gf256_arith_unit_top, the GF(2^8) arithmetic unit.
// Drives request transactions from a queue and checks every response against a field-arithmetic predictor.
// Depends on gfau_pkg, gfau_req_if, gfau_rsp_if and the unit's top level.
module tb;
  import gfau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = FIELD_BITS;
  localparam int unsigned ITEMS_PER_PHASE = 330;
  localparam int unsigned SETTLE_CYCLES = 40;

  // One request to the unit.
  typedef struct {
    gfau_op_e     op;
    logic [W-1:0] a;
    logic [W-1:0] b;
  } gf_request_t;

  // One predicted response, with the request that caused it for the log.
  typedef struct {
    gf_request_t  req;
    logic [W-1:0] value;
    logic [W-1:0] remainder;
    logic         error;
  } gf_answer_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_wr_en_i;
  logic [W-1:0] cfg_wr_data_i;

  gfau_req_if req_if ();
  gfau_rsp_if rsp_if ();

  gf256_arith_unit_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .req_i        (req_if),
    .rsp_o        (rsp_if)
  );

  gf_request_t  pending_requests[$];
  gf_answer_t   awaited_answers[$];
  logic [W-1:0] modulus_low = POLY_RESET[W-1:0];
  bit           calm = 1'b0;
  int unsigned  mismatches = 0;

  // Clock, and every input held at a known value from time zero.
  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = '0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_ADD;
    req_if.operand_a = '0;
    req_if.operand_b = '0;
    rsp_if.ready     = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit on the run.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor of the field arithmetic.
  // ---------------------------------------------------------------------------

  function automatic int degree_of(logic [31:0] p);
    int d;
    d = -1;
    for (int i = 0; i < 32; i++) begin
      if (p[i]) d = i;
    end
    return d;
  endfunction

  // Plain GF(2) polynomial division; the divisor must be nonzero.
  function automatic void poly_divide(input logic [31:0] num, input logic [31:0] den,
                                      output logic [31:0] quo, output logic [31:0] rem);
    int dd;
    int dn;
    quo = '0;
    dd  = degree_of(den);
    dn  = degree_of(num);
    while (dd >= 0 && dn >= dd) begin
      quo[dn - dd] = ~quo[dn - dd];
      num = num ^ (den << (dn - dd));
      dn  = degree_of(num);
    end
    rem = num;
  endfunction

  // Carry-less product without reduction.
  function automatic logic [31:0] carryless_product(logic [31:0] x, logic [31:0] y);
    logic [31:0] p;
    p = '0;
    x = x & 32'h1ffff;
    for (int i = 0; i < 15; i++) begin
      if (y[i]) p = p ^ (x << i);
    end
    return p;
  endfunction

  // Shift-and-add product reduced modulo x^8 plus the configured low bits.
  function automatic logic [W-1:0] field_product(logic [W-1:0] a, logic [W-1:0] b,
                                                 logic [W-1:0] low);
    logic [15:0] acc;
    logic [15:0] modulus;
    acc     = '0;
    modulus = {7'd0, 1'b1, low};
    for (int i = W - 1; i >= 0; i--) begin
      acc = acc << 1;
      if (acc[W]) acc = acc ^ modulus;
      if (b[i]) acc = acc ^ {8'd0, a};
    end
    return acc[W-1:0];
  endfunction

  // Extended Euclid inverse; the top bit says whether an inverse exists.
  function automatic logic [W:0] field_inverse(logic [W-1:0] a, logic [W-1:0] low);
    logic [31:0] r0, r1, t0, t1, q, r, t;
    if (a == '0) return '0;
    r0 = {23'd0, 1'b1, low};
    r1 = {24'd0, a};
    t0 = '0;
    t1 = 32'd1;
    while (r1 != '0) begin
      poly_divide(r0, r1, q, r);
      t  = t0 ^ carryless_product(q, t1);
      r0 = r1;
      r1 = r;
      t0 = t1;
      t1 = t;
    end
    if (r0 != 32'd1) return '0;
    return {1'b1, t0[W-1:0]};
  endfunction

  function automatic gf_answer_t predict_answer(gf_request_t req, logic [W-1:0] low);
    gf_answer_t  ans;
    logic [31:0] quo, rem;
    logic [W:0]  inv;
    ans.req       = req;
    ans.value     = '0;
    ans.remainder = '0;
    ans.error     = 1'b0;
    case (req.op)
      OP_ADD: begin
        ans.value = req.a ^ req.b;
      end
      OP_MUL: begin
        ans.value = field_product(req.a, req.b, low);
      end
      OP_DIV: begin
        if (req.b == '0) begin
          ans.error = 1'b1;
        end else begin
          poly_divide({24'd0, req.a}, {24'd0, req.b}, quo, rem);
          ans.value     = quo[W-1:0];
          ans.remainder = rem[W-1:0];
        end
      end
      default: begin
        inv       = field_inverse(req.a, low);
        ans.value = inv[W-1:0];
        ans.error = ~inv[W];
      end
    endcase
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, response acceptor and checker.
  // ---------------------------------------------------------------------------

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 12);
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Request driver: a transaction is taken when valid and ready are both high.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.operation <= OP_ADD;
      req_if.operand_a <= '0;
      req_if.operand_b <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        awaited_answers.push_back(predict_answer('{gfau_op_e'(req_if.operation),
                                                   req_if.operand_a, req_if.operand_b},
                                                 modulus_low));
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_requests.size() > 0 && !take_break()) begin
          req_if.valid     <= 1'b1;
          req_if.operation <= pending_requests[0].op;
          req_if.operand_a <= pending_requests[0].a;
          req_if.operand_b <= pending_requests[0].b;
          void'(pending_requests.pop_front());
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response side: random back-pressure and a field-by-field check of each transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    gf_answer_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch($sformatf("response with none pending: value %02h rem %02h err %0b",
                                    rsp_if.result_value, rsp_if.remainder_value,
                                    rsp_if.error_flag));
        end else begin
          want = awaited_answers.pop_front();
          if (rsp_if.result_value !== want.value)
            report_mismatch($sformatf("%s a=%02h b=%02h: result_value %02h, expected %02h",
                                      want.req.op.name(), want.req.a, want.req.b,
                                      rsp_if.result_value, want.value));
          if (rsp_if.remainder_value !== want.remainder)
            report_mismatch($sformatf("%s a=%02h b=%02h: remainder_value %02h, expected %02h",
                                      want.req.op.name(), want.req.a, want.req.b,
                                      rsp_if.remainder_value, want.remainder));
          if (rsp_if.error_flag !== want.error)
            report_mismatch($sformatf("%s a=%02h b=%02h: error_flag %0b, expected %0b",
                                      want.req.op.name(), want.req.a, want.req.b,
                                      rsp_if.error_flag, want.error));
        end
      end
      rsp_if.ready <= !take_break();
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  task automatic queue_request(gfau_op_e op, logic [W-1:0] a, logic [W-1:0] b);
    pending_requests.push_back('{op, a, b});
  endtask

  // Operands biased towards zero, one, all ones and low degrees.
  function automatic logic [W-1:0] pick_operand();
    int unsigned sel;
    sel = $urandom_range(15);
    case (sel)
      0, 1:    return '0;
      2:       return '1;
      3:       return 8'h01;
      4, 5:    return W'($urandom_range(7));
      default: return W'($urandom_range(255));
    endcase
  endfunction

  // Wait until every request has gone and every response has come back.
  task automatic wait_until_idle();
    while (pending_requests.size() > 0 || req_if.valid || awaited_answers.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // The modulus register is only written while the unit is idle.
  task automatic write_modulus(logic [W-1:0] low);
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= low;
    modulus_low = low;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [W-1:0] phase_poly[5];
    phase_poly[0] = 8'h00;
    phase_poly[1] = 8'hff;
    phase_poly[2] = POLY_RESET[W-1:0];
    phase_poly[3] = W'($urandom_range(255));
    phase_poly[4] = W'($urandom_range(255));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part under the reset modulus: field extremes and every error case.
    queue_request(OP_ADD, 8'h00, 8'h00);
    queue_request(OP_ADD, 8'hff, 8'hff);
    queue_request(OP_ADD, 8'hff, 8'h00);
    queue_request(OP_MUL, 8'h00, 8'hb7);
    queue_request(OP_MUL, 8'hff, 8'hff);
    queue_request(OP_MUL, 8'h01, 8'hab);
    queue_request(OP_MUL, 8'h80, 8'h02);
    queue_request(OP_MUL, 8'h57, 8'h83);
    queue_request(OP_DIV, 8'h5a, 8'h00);
    queue_request(OP_DIV, 8'h00, 8'h00);
    queue_request(OP_DIV, 8'h00, 8'h05);
    queue_request(OP_DIV, 8'hff, 8'h01);
    queue_request(OP_DIV, 8'hff, 8'hff);
    queue_request(OP_DIV, 8'h03, 8'h80);
    queue_request(OP_DIV, 8'h80, 8'h03);
    queue_request(OP_INV, 8'h00, 8'hff);
    queue_request(OP_INV, 8'h01, 8'h00);
    queue_request(OP_INV, 8'hff, 8'h5c);
    queue_request(OP_INV, 8'h53, 8'h00);
    queue_request(OP_INV, 8'h02, 8'hff);
    queue_request(OP_INV, 8'h80, 8'h00);
    wait_until_idle();

    // Random phases; the third runs without any idling on either side.
    for (int ph = 0; ph < 5; ph++) begin
      write_modulus(phase_poly[ph]);
      calm = (ph == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        queue_request(gfau_op_e'($urandom_range(3)), pick_operand(), pick_operand());
      wait_until_idle();
    end
    calm = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
